// ===== design/aocs_pkg.sv =====
`timescale 1ns / 1ps

package aocs_pkg;

    // raw sample fields as they travel on the input stream
    localparam int RAW_W       = 12;
    localparam int IN_TDATA_W  = 40;
    localparam int U_LSB       = 0;
    localparam int W_LSB       = 12;
    localparam int B_LSB       = 24;

    // configuration
    localparam int SCALE_W     = 24;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    localparam logic [1:0] REG_CURRENT_INVERT = 2'd0;
    localparam logic [1:0] REG_CURRENT_SCALE  = 2'd1;
    localparam logic [1:0] REG_BUS_SCALE      = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd1048576;

    // result fields
    localparam int CUR_W       = 37;
    localparam int CURV_W      = 38;
    localparam int BUS_W       = 36;
    localparam int REF_W       = 37;
    localparam int OUT_TDATA_W = 192;
    localparam int PAD_W       = OUT_TDATA_W - (CUR_W + CURV_W + CUR_W + BUS_W + REF_W + 1);

    typedef logic signed [CUR_W-1:0]  cur_t;
    typedef logic signed [CURV_W-1:0] curv_t;

endpackage

// ===== design/adc_offset_calib_current_scale_core.sv =====
`timescale 1ns / 1ps

// Offset calibration and phase current / bus voltage scaling for a three-channel
// ADC front end. A transfer with tuser 0 is one calibration step: 2^CAL_LOG2 steps
// accumulate the samples, and one more step averages them into the offsets,
// latches the bus reference and raises calib_done. A transfer with tuser 1 is a
// measurement that gives the U and W currents (offset removed, signed, scaled),
// V as -(U+W), the scaled bus voltage and its change from the reference, all with
// 20 fraction bits. One item is taken every clock cycle while s_axis_tready is high;
// a result passes through one register stage after the multipliers and one output
// register. While a result waits for m_axis_tready one more item can still enter
// the product stage, after which s_axis_tready drops until the output register is
// free again.
module adc_offset_calib_current_scale_core
    import aocs_pkg::*;
#(
    parameter int CAL_LOG2 = 10,
    parameter int ADC_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // phase_u_raw[11:0], phase_w_raw[23:12], bus_raw[35:24], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // current_u[36:0], current_v[74:37], current_w[111:75], bus_voltage[147:112],
    // bus_change[184:148], calib_done[185], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int SAMPLE_W = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam int SUM_W    = SAMPLE_W + CAL_LOG2;
    localparam int CNT_W    = CAL_LOG2 + 1;
    localparam int PROD_W   = SAMPLE_W + SCALE_W + 2;
    localparam int UPROD_W  = SAMPLE_W + SCALE_W;
    localparam logic [CNT_W-1:0] CAL_STEPS = CNT_W'(1) << CAL_LOG2;

    // configuration registers
    logic               current_invert_reg;
    logic [SCALE_W-1:0] current_scale_reg;
    logic [SCALE_W-1:0] bus_scale_reg;
    logic               cfg_write;

    // calibration state
    logic [SUM_W-1:0]    sum_u_reg, sum_w_reg, sum_bus_reg;
    logic [SUM_W-1:0]    sum_u_next, sum_w_next, sum_bus_next;
    logic [CNT_W-1:0]    calib_count_reg, calib_count_next;
    logic [SAMPLE_W-1:0] offset_u_reg, offset_w_reg, offset_bus_reg;
    logic [SAMPLE_W-1:0] offset_u_next, offset_w_next, offset_bus_next;
    logic [REF_W-1:0]    bus_reference_reg, bus_reference_next;
    logic                done_flag_reg, done_flag_next;

    // input side
    logic                   s_accept;
    logic [SAMPLE_W-1:0]    sample_u, sample_w, sample_b;
    logic signed [SAMPLE_W:0]   diff_u, diff_w;
    logic signed [PROD_W-1:0]   prod_u, prod_w;
    logic [UPROD_W-1:0]     prod_bus, prod_ref;

    // product stage
    logic               p_valid_reg;
    logic               p_meas_reg;
    cur_t               p_cu_reg, p_cw_reg;
    logic [BUS_W-1:0]   p_bv_reg;
    logic [REF_W-1:0]   p_ref_reg;
    logic               p_done_reg;
    logic               p_ready;

    // output stage
    logic               m_valid_reg;
    logic               out_ready;
    cur_t               cu_sel, cw_sel;
    curv_t              cv_calc;
    logic [REF_W-1:0]   bc_calc;
    cur_t               cu_reg, cw_reg;
    curv_t              cv_reg;
    logic [BUS_W-1:0]   bv_reg;
    logic [REF_W-1:0]   bc_reg;
    logic               done_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_invert_reg <= 1'b0;
            current_scale_reg  <= SCALE_RESET;
            bus_scale_reg      <= SCALE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_CURRENT_INVERT: current_invert_reg <= pwdata[0];
                REG_CURRENT_SCALE:  current_scale_reg  <= pwdata[SCALE_W-1:0];
                REG_BUS_SCALE:      bus_scale_reg      <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CURRENT_INVERT: prdata = APB_DATA_W'(current_invert_reg);
            REG_CURRENT_SCALE:  prdata = APB_DATA_W'(current_scale_reg);
            REG_BUS_SCALE:      prdata = APB_DATA_W'(bus_scale_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign p_ready       = !p_valid_reg || out_ready;
    assign s_axis_tready = p_ready;
    assign s_accept      = s_axis_tvalid && p_ready;
    assign m_axis_tvalid = m_valid_reg;

    assign sample_u = s_axis_tdata[U_LSB +: SAMPLE_W];
    assign sample_w = s_axis_tdata[W_LSB +: SAMPLE_W];
    assign sample_b = s_axis_tdata[B_LSB +: SAMPLE_W];

    // ---------------- calibration ----------------
    always_comb begin
        sum_u_next         = sum_u_reg;
        sum_w_next         = sum_w_reg;
        sum_bus_next       = sum_bus_reg;
        calib_count_next   = calib_count_reg;
        offset_u_next      = offset_u_reg;
        offset_w_next      = offset_w_reg;
        offset_bus_next    = offset_bus_reg;
        bus_reference_next = bus_reference_reg;
        done_flag_next     = done_flag_reg;
        if (calib_count_reg == CAL_STEPS) begin
            // run complete: average the sums into the offsets
            offset_u_next    = sum_u_reg[SUM_W-1:CAL_LOG2];
            offset_w_next    = sum_w_reg[SUM_W-1:CAL_LOG2];
            offset_bus_next  = sum_bus_reg[SUM_W-1:CAL_LOG2];
            bus_reference_next = REF_W'(prod_ref);
            calib_count_next = '0;
            done_flag_next   = 1'b1;
        end else if (calib_count_reg == '0) begin
            // first step of a run restarts the sums
            sum_u_next       = SUM_W'(sample_u);
            sum_w_next       = SUM_W'(sample_w);
            sum_bus_next     = SUM_W'(sample_b);
            calib_count_next = CNT_W'(1);
            done_flag_next   = 1'b0;
        end else begin
            sum_u_next       = sum_u_reg + SUM_W'(sample_u);
            sum_w_next       = sum_w_reg + SUM_W'(sample_w);
            sum_bus_next     = sum_bus_reg + SUM_W'(sample_b);
            calib_count_next = calib_count_reg + CNT_W'(1);
        end
    end

    assign prod_ref = UPROD_W'(sum_bus_reg[SUM_W-1:CAL_LOG2]) * UPROD_W'(bus_scale_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_u_reg         <= '0;
            sum_w_reg         <= '0;
            sum_bus_reg       <= '0;
            calib_count_reg   <= '0;
            offset_u_reg      <= '0;
            offset_w_reg      <= '0;
            offset_bus_reg    <= '0;
            bus_reference_reg <= '0;
            done_flag_reg     <= 1'b0;
        end else if (s_accept && !s_axis_tuser) begin
            sum_u_reg         <= sum_u_next;
            sum_w_reg         <= sum_w_next;
            sum_bus_reg       <= sum_bus_next;
            calib_count_reg   <= calib_count_next;
            offset_u_reg      <= offset_u_next;
            offset_w_reg      <= offset_w_next;
            offset_bus_reg    <= offset_bus_next;
            bus_reference_reg <= bus_reference_next;
            done_flag_reg     <= done_flag_next;
        end
    end

    // ---------------- measurement products ----------------
    assign diff_u   = $signed({1'b0, sample_u}) - $signed({1'b0, offset_u_reg});
    assign diff_w   = $signed({1'b0, sample_w}) - $signed({1'b0, offset_w_reg});
    assign prod_u   = PROD_W'(diff_u) * PROD_W'($signed({1'b0, current_scale_reg}));
    assign prod_w   = PROD_W'(diff_w) * PROD_W'($signed({1'b0, current_scale_reg}));
    assign prod_bus = UPROD_W'(sample_b) * UPROD_W'(bus_scale_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_meas_reg <= s_axis_tuser;
            p_cu_reg   <= CUR_W'(prod_u);
            p_cw_reg   <= CUR_W'(prod_w);
            p_bv_reg   <= BUS_W'(prod_bus);
            // reference as seen by this item, a later calibration may move it
            p_ref_reg  <= bus_reference_reg;
            p_done_reg <= s_axis_tuser ? done_flag_reg : done_flag_next;
        end
    end

    // ---------------- sign, V phase and bus change ----------------
    assign cu_sel  = current_invert_reg ? -p_cu_reg : p_cu_reg;
    assign cw_sel  = current_invert_reg ? -p_cw_reg : p_cw_reg;
    assign cv_calc = -(CURV_W'(cu_sel) + CURV_W'(cw_sel));
    assign bc_calc = REF_W'(p_bv_reg) - p_ref_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p_valid_reg) begin
            cu_reg   <= p_meas_reg ? cu_sel  : '0;
            cw_reg   <= p_meas_reg ? cw_sel  : '0;
            cv_reg   <= p_meas_reg ? cv_calc : '0;
            bv_reg   <= p_meas_reg ? p_bv_reg : '0;
            bc_reg   <= p_meas_reg ? bc_calc : '0;
            done_reg <= p_done_reg;
        end
    end

    assign m_axis_tdata = {{PAD_W{1'b0}}, done_reg, bc_reg, bv_reg, cw_reg, cv_reg, cu_reg};

endmodule

// ===== test/tb_adc_offset_calib_current_scale_core.sv =====
`timescale 1ns / 1ps

module tb_adc_offset_calib_current_scale_core;
    import aocs_pkg::*;

    localparam int CAL_LOG2       = 10;
    localparam int ADC_BITS       = 12;
    localparam int CAL_STEPS      = 1 << CAL_LOG2;
    localparam int RAW_MAX        = (1 << RAW_W) - 1;
    localparam logic [RAW_W-1:0] RAW_FULL = RAW_W'(RAW_MAX);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    localparam bit KIND_CAL  = 1'b0;
    localparam bit KIND_MEAS = 1'b1;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // result field positions in m_axis_tdata
    localparam int V_LSB    = CUR_W;
    localparam int WC_LSB   = V_LSB + CURV_W;
    localparam int BV_LSB   = WC_LSB + CUR_W;
    localparam int BC_LSB   = BV_LSB + BUS_W;
    localparam int DONE_BIT = BC_LSB + REF_W;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic signed [CUR_W-1:0]  cur_u;
        logic signed [CURV_W-1:0] cur_v;
        logic signed [CUR_W-1:0]  cur_w;
        logic [BUS_W-1:0]         bus_v;
        logic signed [REF_W-1:0]  bus_delta;
        logic                     done;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // phase_u_raw[11:0], phase_w_raw[23:12], bus_raw[35:24], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // kind
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // current_u, current_v, current_w, bus_voltage, bus_change, calib_done, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // register copies
    logic               cfg_invert;
    logic [SCALE_W-1:0] cfg_current_scale;
    logic [SCALE_W-1:0] cfg_bus_scale;

    // calibration state
    logic [21:0]      cal_sum_u, cal_sum_w, cal_sum_bus;
    logic [10:0]      cal_count;
    logic [RAW_W-1:0] off_u, off_w, off_bus;
    logic [REF_W-1:0] bus_ref;
    logic             cal_done;

    reading_t pending_readings[$];
    int       failures = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       quiet_cycles = 0;

    adc_offset_calib_current_scale_core #(
        .CAL_LOG2(CAL_LOG2),
        .ADC_BITS(ADC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic reading_t predict_reading(bit kind, logic [RAW_W-1:0] u,
                                                 logic [RAW_W-1:0] w, logic [RAW_W-1:0] b);
        reading_t r;
        longint   vu, vw, vb, vsum;
        r.cur_u     = '0;
        r.cur_v     = '0;
        r.cur_w     = '0;
        r.bus_v     = '0;
        r.bus_delta = '0;
        if (kind == KIND_CAL) begin
            if (cal_count == 0) begin
                cal_sum_u   = '0;
                cal_sum_w   = '0;
                cal_sum_bus = '0;
                cal_done    = 1'b0;
            end
            if (cal_count < CAL_STEPS) begin
                cal_sum_u   = cal_sum_u + u;
                cal_sum_w   = cal_sum_w + w;
                cal_sum_bus = cal_sum_bus + b;
                cal_count   = cal_count + 1'b1;
            end else begin
                off_u     = RAW_W'(cal_sum_u >> CAL_LOG2);
                off_w     = RAW_W'(cal_sum_w >> CAL_LOG2);
                off_bus   = RAW_W'(cal_sum_bus >> CAL_LOG2);
                vb        = longint'(off_bus) * longint'(cfg_bus_scale);
                bus_ref   = vb[REF_W-1:0];
                cal_count = '0;
                cal_done  = 1'b1;
            end
        end else begin
            vu = (longint'(u) - longint'(off_u)) * longint'(cfg_current_scale);
            vw = (longint'(w) - longint'(off_w)) * longint'(cfg_current_scale);
            if (cfg_invert) begin
                vu = -vu;
                vw = -vw;
            end
            vsum        = -(vu + vw);
            vb          = longint'(b) * longint'(cfg_bus_scale);
            r.cur_u     = vu[CUR_W-1:0];
            r.cur_w     = vw[CUR_W-1:0];
            r.cur_v     = vsum[CURV_W-1:0];
            r.bus_v     = vb[BUS_W-1:0];
            vb          = vb - longint'(bus_ref);
            r.bus_delta = vb[REF_W-1:0];
        end
        r.done = cal_done;
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] sample_near(int centre);
        int v;
        v = centre - 16 + int'($urandom_range(32));
        if (v < 0) v = 0;
        if (v > RAW_MAX) v = RAW_MAX;
        return v[RAW_W-1:0];
    endfunction

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;  recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 69; recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;  recv_stall_pct = 69;
            end
            default: begin
                send_idle_pct = 23; recv_stall_pct = 23;
            end
        endcase
    endtask

    task automatic send_sample(bit kind, logic [RAW_W-1:0] u, logic [RAW_W-1:0] w,
                               logic [RAW_W-1:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = '0;
        s_axis_tdata[U_LSB +: RAW_W] = u;
        s_axis_tdata[W_LSB +: RAW_W] = w;
        s_axis_tdata[B_LSB +: RAW_W] = b;
        do @(posedge aclk); while (!s_axis_tready);
        pending_readings.push_back(predict_reading(kind, u, w, b));
    endtask

    task automatic send_random_measurement();
        send_sample(KIND_MEAS, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(bit write, logic [1:0] idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_CURRENT_INVERT: cfg_invert        = value[0];
            REG_CURRENT_SCALE:  cfg_current_scale = value[SCALE_W-1:0];
            REG_BUS_SCALE:      cfg_bus_scale     = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, REG_CURRENT_INVERT, '0, rd);
        if (rd !== APB_DATA_W'(cfg_invert)) begin
            $error("current_invert readback: expected %0d, actual %0d", cfg_invert, rd);
            failures++;
        end
        apb_access(1'b0, REG_CURRENT_SCALE, '0, rd);
        if (rd !== APB_DATA_W'(cfg_current_scale)) begin
            $error("current_scale readback: expected %0d, actual %0d", cfg_current_scale, rd);
            failures++;
        end
        apb_access(1'b0, REG_BUS_SCALE, '0, rd);
        if (rd !== APB_DATA_W'(cfg_bus_scale)) begin
            $error("bus_scale readback: expected %0d, actual %0d", cfg_bus_scale, rd);
            failures++;
        end
    endtask

    task automatic write_random_config();
        write_register(REG_CURRENT_INVERT, $urandom);
        write_register(REG_CURRENT_SCALE, $urandom);
        write_register(REG_BUS_SCALE, $urandom);
        check_registers();
    endtask

    // offsets are still zero here
    task automatic test_reset_measurement();
        set_idle(IDLE_NONE);
        check_registers();
        send_sample(KIND_MEAS, '0, '0, '0);
        send_sample(KIND_MEAS, RAW_FULL, RAW_FULL, RAW_FULL);
        send_sample(KIND_MEAS, '0, RAW_FULL, RAW_FULL);
        send_sample(KIND_MEAS, RAW_FULL, '0, '0);
        send_random_measurement();
        send_random_measurement();
    endtask

    task automatic test_register_extremes();
        wait_drained();
        write_register(REG_CURRENT_INVERT, 32'hFFFF_FFFF);
        write_register(REG_CURRENT_SCALE, 32'hFFFF_FFFF);
        write_register(REG_BUS_SCALE, 32'hA5FF_FFFF);
        // nothing lives at this address
        write_register(REG_UNMAPPED, $urandom);
        check_registers();
        send_sample(KIND_MEAS, '0, RAW_FULL, RAW_FULL);
        send_sample(KIND_MEAS, RAW_FULL, '0, '0);
        send_sample(KIND_MEAS, '0, '0, RAW_FULL);
        send_sample(KIND_MEAS, RAW_FULL, RAW_FULL, '0);
        wait_drained();
        write_register(REG_CURRENT_INVERT, 32'hFFFF_FFFE);
        write_register(REG_CURRENT_SCALE, 32'h5A00_0000);
        write_register(REG_BUS_SCALE, 0);
        check_registers();
        send_random_measurement();
        send_random_measurement();
        // a short calibration start: done stays low and outputs are zero
        send_sample(KIND_CAL, RAW_FULL, '0, RAW_FULL);
        send_sample(KIND_CAL, '0, RAW_FULL, '0);
        send_sample(KIND_CAL, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
    endtask

    task automatic test_calibration_run();
        int  cu, cw, cb;
        int  n;
        bit  finished;
        wait_drained();
        write_random_config();
        cu = $urandom_range(RAW_MAX);
        cw = $urandom_range(RAW_MAX);
        cb = $urandom_range(RAW_MAX);
        n = 0;
        finished = 1'b0;
        while (!finished) begin
            set_idle(idle_mode_t'((n / 256) % 4));
            if ($urandom_range(99) < 15) begin
                send_random_measurement();
            end else begin
                send_sample(KIND_CAL, sample_near(cu), sample_near(cw), sample_near(cb));
                finished = (cal_count == 0);
            end
            n++;
        end
    endtask

    task automatic test_measure_after_calibration();
        int n;
        wait_drained();
        // bus reference keeps the scale it was latched with
        write_register(REG_BUS_SCALE, $urandom);
        write_register(REG_CURRENT_INVERT, APB_DATA_W'(~cfg_invert));
        check_registers();
        for (n = 0; n < 400; n++) begin
            if (n == 200) begin
                wait_drained();
                write_register(REG_CURRENT_SCALE, 32'h00FF_FFFF);
                write_register(REG_BUS_SCALE, 32'h00FF_FFFF);
                write_register(REG_CURRENT_INVERT, 1);
                check_registers();
            end
            set_idle(idle_mode_t'((n / 50) % 4));
            if ($urandom_range(1))
                send_sample(KIND_MEAS, sample_near(int'(off_u)), sample_near(int'(off_w)),
                            sample_near(int'(off_bus)));
            else
                send_random_measurement();
        end
    endtask

    // a new run clears done while the old offsets stay in use
    task automatic test_recalibration();
        int cu, cw, cb;
        int n;
        wait_drained();
        write_random_config();
        cu = $urandom_range(RAW_MAX);
        cw = $urandom_range(RAW_MAX);
        cb = $urandom_range(RAW_MAX);
        for (n = 0; n < 250; n++) begin
            set_idle(idle_mode_t'((n / 40) % 4));
            if ($urandom_range(99) < 60)
                send_sample(KIND_CAL, sample_near(cu), sample_near(cw), sample_near(cb));
            else
                send_random_measurement();
        end
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_readings
        reading_t exp_r;
        reading_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.cur_u     = m_axis_tdata[0 +: CUR_W];
            got.cur_v     = m_axis_tdata[V_LSB +: CURV_W];
            got.cur_w     = m_axis_tdata[WC_LSB +: CUR_W];
            got.bus_v     = m_axis_tdata[BV_LSB +: BUS_W];
            got.bus_delta = m_axis_tdata[BC_LSB +: REF_W];
            got.done      = m_axis_tdata[DONE_BIT];
            if (pending_readings.size() == 0) begin
                $error("result transfer with no reading outstanding");
                failures++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (got.cur_u !== exp_r.cur_u) begin
                    $error("current_u: expected %0d, actual %0d", exp_r.cur_u, got.cur_u);
                    failures++;
                end
                if (got.cur_v !== exp_r.cur_v) begin
                    $error("current_v: expected %0d, actual %0d", exp_r.cur_v, got.cur_v);
                    failures++;
                end
                if (got.cur_w !== exp_r.cur_w) begin
                    $error("current_w: expected %0d, actual %0d", exp_r.cur_w, got.cur_w);
                    failures++;
                end
                if (got.bus_v !== exp_r.bus_v) begin
                    $error("bus_voltage: expected %0d, actual %0d", exp_r.bus_v, got.bus_v);
                    failures++;
                end
                if (got.bus_delta !== exp_r.bus_delta) begin
                    $error("bus_change: expected %0d, actual %0d",
                           exp_r.bus_delta, got.bus_delta);
                    failures++;
                end
                if (got.done !== exp_r.done) begin
                    $error("calib_done: expected %0d, actual %0d", exp_r.done, got.done);
                    failures++;
                end
            end
        end
    end

    // any transfer on either stream or the register port counts as progress
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_adc_offset_calib_current_scale_core: FAIL");
            $finish;
        end
    end

    initial begin
        cfg_invert        = 1'b0;
        cfg_current_scale = SCALE_RESET;
        cfg_bus_scale     = SCALE_RESET;
        cal_sum_u         = '0;
        cal_sum_w         = '0;
        cal_sum_bus       = '0;
        cal_count         = '0;
        off_u             = '0;
        off_w             = '0;
        off_bus           = '0;
        bus_ref           = '0;
        cal_done          = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_measurement();
        test_register_extremes();
        test_calibration_run();
        test_measure_after_calibration();
        test_recalibration();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("tb_adc_offset_calib_current_scale_core: PASS");
        else
            $display("tb_adc_offset_calib_current_scale_core: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/aocs_pkg.sv
design/adc_offset_calib_current_scale_core.sv
test/tb_adc_offset_calib_current_scale_core.sv
